// ----- design/ethernet_header_classifier_defines.svh -----
// Assertion macros for the Ethernet header classifier.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef ETHERNET_HEADER_CLASSIFIER_DEFINES_SVH
`define ETHERNET_HEADER_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define EHC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define EHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ehc_pkg.sv -----
// Shared constants, codes and structs of the Ethernet header classifier.
// Depends on nothing; the parser, counter bank and top level refer to it by scoped names.
`default_nettype none

package ehc_pkg;

    // Counter width and counter memory geometry
    localparam int COUNT_WIDTH = 32;
    localparam int L3_DEPTH    = 3;
    localparam int L4_DEPTH    = 4;
    localparam int L3_AW       = (L3_DEPTH > 1) ? $clog2(L3_DEPTH) : 1;
    localparam int L4_AW       = (L4_DEPTH > 1) ? $clog2(L4_DEPTH) : 1;

    // Network counter entries
    localparam logic [L3_AW-1:0] L3_IPV6 = L3_AW'(0);
    localparam logic [L3_AW-1:0] L3_IPV4 = L3_AW'(1);
    localparam logic [L3_AW-1:0] L3_ARP  = L3_AW'(2);

    // Transport counter entries (the ICMPv6 entry is never bumped)
    localparam logic [L4_AW-1:0] L4_TCP    = L4_AW'(0);
    localparam logic [L4_AW-1:0] L4_UDP    = L4_AW'(1);
    localparam logic [L4_AW-1:0] L4_ICMP   = L4_AW'(2);
    localparam logic [L4_AW-1:0] L4_ICMPV6 = L4_AW'(3);

    // EtherTypes
    localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
    localparam logic [15:0] ETYPE_QINQ  = 16'h88A8;
    localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETYPE_ARP   = 16'h0806;

    // IPv4 protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Header offsets and minimum lengths
    localparam logic [15:0] OFS_TYPE_HI  = 16'd12;
    localparam logic [15:0] OFS_TYPE_LO  = 16'd13;
    localparam logic [15:0] OFS_IHL      = 16'd14;
    localparam logic [15:0] OFS_PROTO    = 16'd23;
    localparam logic [15:0] OFS_SRC_LO   = 16'd26;
    localparam logic [15:0] OFS_SRC_HI   = 16'd29;
    localparam logic [15:0] OFS_DST_LO   = 16'd30;
    localparam logic [15:0] OFS_DST_HI   = 16'd33;
    localparam logic [6:0]  L3_BASE      = 7'd14;
    localparam logic [15:0] MIN_ETH      = 16'd14;
    localparam logic [15:0] MIN_VLAN     = 16'd18;
    localparam logic [15:0] MIN_IPV6     = 16'd54;
    localparam logic [15:0] MIN_IPV4     = 16'd34;
    localparam logic [15:0] MIN_ARP      = 16'd22;
    localparam logic [6:0]  NEED_TCP     = 7'd20;
    localparam logic [6:0]  NEED_SHORT   = 7'd8;
    localparam logic [15:0] LEN_MAX      = 16'hFFFF;

    // Packet classes
    typedef enum logic [2:0] {
        CLS_OTHER = 3'd0,
        CLS_VLAN  = 3'd1,
        CLS_IPV6  = 3'd2,
        CLS_IPV4  = 3'd3,
        CLS_TCP   = 3'd4,
        CLS_UDP   = 3'd5,
        CLS_ICMP  = 3'd6,
        CLS_ARP   = 3'd7
    } t_class;

    // Classified frame, ready for counting
    typedef struct packed {
        logic              verdict;
        t_class            cls;
        logic              report;
        logic [15:0]       frame_length;
        logic [15:0]       ether_type;
        logic [7:0]        ip_protocol;
        logic [31:0]       src_addr;
        logic [31:0]       dst_addr;
        logic [15:0]       src_port;
        logic [15:0]       dst_port;
        logic              l3_bump;
        logic [L3_AW-1:0]  l3_idx;
        logic              l4_bump;
        logic [L4_AW-1:0]  l4_idx;
    } t_frame;

    // Counter read request, issued as the final byte is taken
    typedef struct packed {
        logic              en;
        logic [L3_AW-1:0]  l3_idx;
        logic [L4_AW-1:0]  l4_idx;
    } t_cnt_rd;

    // Counter write-back, issued as a frame leaves the count stage
    typedef struct packed {
        logic              en;
        logic              l3_bump;
        logic [L3_AW-1:0]  l3_idx;
        logic              l4_bump;
        logic [L4_AW-1:0]  l4_idx;
    } t_cnt_upd;

endpackage

`default_nettype wire

// ----- design/ehc_in_if.sv -----
// Byte stream channel into the classifier: valid, ready, data byte, last flag.
// Depends on nothing.
`default_nettype none

interface ehc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ----- design/ehc_out_if.sv -----
// Verdict channel out of the classifier: valid, ready and one result per frame.
// Depends on nothing.
`default_nettype none

interface ehc_out_if;
    logic        valid;
    logic        ready;
    logic        verdict;
    logic [2:0]  packet_class;
    logic        report_valid;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] l3_count;
    logic [31:0] l4_count;

    modport source (output valid, verdict, packet_class, report_valid, frame_length,
                    ether_type, ip_protocol, src_addr, dst_addr, src_port, dst_port,
                    l3_count, l4_count, input ready);
    modport sink   (input valid, verdict, packet_class, report_valid, frame_length,
                    ether_type, ip_protocol, src_addr, dst_addr, src_port, dst_port,
                    l3_count, l4_count, output ready);
endinterface

`default_nettype wire

// ----- design/ehc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// A read of the address written in the same cycle returns the old contents.
`default_nettype none

module ehc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/ehc_parser.sv -----
// Header capture at fixed and header-length-based byte offsets, and frame classification on the final byte.
// Depends on ehc_pkg.
`default_nettype none

module ehc_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_last_byte,
    output ehc_pkg::t_frame      o_frame
);

    logic [15:0] r_byte_index, n_byte_index;
    logic [15:0] r_type, n_type;
    logic [3:0]  r_hw, n_hw;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src_addr, n_src_addr;
    logic [31:0] r_dst_addr, n_dst_addr;
    logic [15:0] r_src_port, n_src_port;
    logic [15:0] r_dst_port, n_dst_port;

    logic [15:0] len;
    logic [6:0]  base;
    logic [6:0]  need;
    logic        has_l4;

    // Capture header fields as their bytes go by
    always_comb begin
        n_hw       = (r_byte_index == ehc_pkg::OFS_IHL) ? i_data_byte[3:0] : r_hw;
        n_type     = r_type;
        n_proto    = r_proto;
        n_src_addr = r_src_addr;
        n_dst_addr = r_dst_addr;
        n_src_port = r_src_port;
        n_dst_port = r_dst_port;
        base       = ehc_pkg::L3_BASE + {1'b0, n_hw, 2'b00};
        if (r_byte_index == ehc_pkg::OFS_TYPE_HI) begin
            n_type[15:8] = i_data_byte;
        end
        if (r_byte_index == ehc_pkg::OFS_TYPE_LO) begin
            n_type[7:0] = i_data_byte;
        end
        if (r_byte_index == ehc_pkg::OFS_PROTO) begin
            n_proto = i_data_byte;
        end
        if (r_byte_index >= ehc_pkg::OFS_SRC_LO && r_byte_index <= ehc_pkg::OFS_SRC_HI) begin
            n_src_addr = {r_src_addr[23:0], i_data_byte};
        end
        if (r_byte_index >= ehc_pkg::OFS_DST_LO && r_byte_index <= ehc_pkg::OFS_DST_HI) begin
            n_dst_addr = {r_dst_addr[23:0], i_data_byte};
        end
        if (r_byte_index == 16'(base)) begin
            n_src_port[15:8] = i_data_byte;
        end
        if (r_byte_index == 16'(base + 7'd1)) begin
            n_src_port[7:0] = i_data_byte;
        end
        if (r_byte_index == 16'(base + 7'd2)) begin
            n_dst_port[15:8] = i_data_byte;
        end
        if (r_byte_index == 16'(base + 7'd3)) begin
            n_dst_port[7:0] = i_data_byte;
        end
        len          = (r_byte_index == ehc_pkg::LEN_MAX) ? ehc_pkg::LEN_MAX
                                                          : r_byte_index + 16'd1;
        n_byte_index = len;
    end

    // Classify the frame from the fields as they stand after this byte
    always_comb begin
        o_frame              = '0;
        o_frame.cls          = ehc_pkg::CLS_OTHER;
        o_frame.frame_length = len;
        need                 = '0;
        has_l4               = 1'b0;
        if (len >= ehc_pkg::MIN_ETH) begin
            o_frame.ether_type = n_type;
            if (n_type == ehc_pkg::ETYPE_VLAN || n_type == ehc_pkg::ETYPE_QINQ) begin
                o_frame.cls     = ehc_pkg::CLS_VLAN;
                o_frame.verdict = (len < ehc_pkg::MIN_VLAN);
            end else if (n_type == ehc_pkg::ETYPE_IPV6) begin
                o_frame.cls     = ehc_pkg::CLS_IPV6;
                o_frame.l3_bump = 1'b1;
                o_frame.l3_idx  = ehc_pkg::L3_IPV6;
                o_frame.verdict = (len < ehc_pkg::MIN_IPV6);
            end else if (n_type == ehc_pkg::ETYPE_IPV4) begin
                if (len >= ehc_pkg::MIN_IPV4) begin
                    o_frame.l3_bump     = 1'b1;
                    o_frame.l3_idx      = ehc_pkg::L3_IPV4;
                    o_frame.ip_protocol = n_proto;
                    o_frame.src_addr    = n_src_addr;
                    o_frame.dst_addr    = n_dst_addr;
                    o_frame.cls         = ehc_pkg::CLS_IPV4;
                    if (n_proto == ehc_pkg::PROTO_TCP) begin
                        o_frame.cls    = ehc_pkg::CLS_TCP;
                        o_frame.l4_idx = ehc_pkg::L4_TCP;
                        need           = ehc_pkg::NEED_TCP;
                        has_l4         = 1'b1;
                    end else if (n_proto == ehc_pkg::PROTO_UDP) begin
                        o_frame.cls    = ehc_pkg::CLS_UDP;
                        o_frame.l4_idx = ehc_pkg::L4_UDP;
                        need           = ehc_pkg::NEED_SHORT;
                        has_l4         = 1'b1;
                    end else if (n_proto == ehc_pkg::PROTO_ICMP) begin
                        o_frame.cls    = ehc_pkg::CLS_ICMP;
                        o_frame.l4_idx = ehc_pkg::L4_ICMP;
                        need           = ehc_pkg::NEED_SHORT;
                        has_l4         = 1'b1;
                    end
                    // Drop when the transport header is cut off
                    if (has_l4 && len < 16'(base + need)) begin
                        o_frame.verdict = 1'b1;
                    end else begin
                        o_frame.report  = 1'b1;
                        o_frame.l4_bump = has_l4;
                        if (n_proto == ehc_pkg::PROTO_TCP || n_proto == ehc_pkg::PROTO_UDP) begin
                            o_frame.src_port = n_src_port;
                            o_frame.dst_port = n_dst_port;
                        end
                    end
                end
            end else if (n_type == ehc_pkg::ETYPE_ARP) begin
                if (len >= ehc_pkg::MIN_ARP) begin
                    o_frame.cls     = ehc_pkg::CLS_ARP;
                    o_frame.l3_bump = 1'b1;
                    o_frame.l3_idx  = ehc_pkg::L3_ARP;
                    o_frame.report  = 1'b1;
                end
            end
        end
    end

    // Advance per accepted byte; clear the frame state on reset and on the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_byte_index <= '0;
            r_type       <= '0;
            r_hw         <= '0;
            r_proto      <= '0;
            r_src_addr   <= '0;
            r_dst_addr   <= '0;
            r_src_port   <= '0;
            r_dst_port   <= '0;
        end else if (i_accept) begin
            r_byte_index <= n_byte_index;
            r_type       <= n_type;
            r_hw         <= n_hw;
            r_proto      <= n_proto;
            r_src_addr   <= n_src_addr;
            r_dst_addr   <= n_dst_addr;
            r_src_port   <= n_src_port;
            r_dst_port   <= n_dst_port;
        end
    end

endmodule

`default_nettype wire

// ----- design/ehc_counter_bank.sv -----
// Class counters in two RAMs (network and transport) with read-modify-write.
// Depends on ehc_pkg and ehc_ram; forwards a write that lands on the read cycle.
`default_nettype none

module ehc_counter_bank (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ehc_pkg::t_cnt_rd              i_rd,
    input  wire ehc_pkg::t_cnt_upd             i_upd,
    output logic [ehc_pkg::COUNT_WIDTH-1:0]    o_l3_next,
    output logic [ehc_pkg::COUNT_WIDTH-1:0]    o_l4_next
);

    localparam int CW = ehc_pkg::COUNT_WIDTH;

    logic                        l3_wr, l4_wr;
    logic [CW-1:0]               l3_dout, l4_dout;
    logic [CW-1:0]               l3_cur, l4_cur;
    logic [ehc_pkg::L3_DEPTH-1:0] r_l3_vld;
    logic [ehc_pkg::L4_DEPTH-1:0] r_l4_vld;
    logic                        r_l3_rd_vld, r_l4_rd_vld;
    logic                        r_l3_fwd_hit, r_l4_fwd_hit;
    logic [CW-1:0]               r_l3_fwd_data, r_l4_fwd_data;

    assign l3_wr = i_upd.en && i_upd.l3_bump;
    assign l4_wr = i_upd.en && i_upd.l4_bump;

    ehc_ram #(
        .WIDTH (CW),
        .DEPTH (ehc_pkg::L3_DEPTH)
    ) u_l3_ram (
        .i_clk     (i_clk),
        .i_wr_en   (l3_wr),
        .i_wr_addr (i_upd.l3_idx),
        .i_wr_data (o_l3_next),
        .i_rd_en   (i_rd.en),
        .i_rd_addr (i_rd.l3_idx),
        .o_rd_data (l3_dout)
    );

    ehc_ram #(
        .WIDTH (CW),
        .DEPTH (ehc_pkg::L4_DEPTH)
    ) u_l4_ram (
        .i_clk     (i_clk),
        .i_wr_en   (l4_wr),
        .i_wr_addr (i_upd.l4_idx),
        .i_wr_data (o_l4_next),
        .i_rd_en   (i_rd.en),
        .i_rd_addr (i_rd.l4_idx),
        .o_rd_data (l4_dout)
    );

    // Pick forwarded, stored or reset value, then increment
    assign l3_cur    = r_l3_fwd_hit ? r_l3_fwd_data : (r_l3_rd_vld ? l3_dout : '0);
    assign l4_cur    = r_l4_fwd_hit ? r_l4_fwd_data : (r_l4_rd_vld ? l4_dout : '0);
    assign o_l3_next = l3_cur + CW'(1);
    assign o_l4_next = l4_cur + CW'(1);

    // Track written entries so unwritten ones read as zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l3_vld <= '0;
            r_l4_vld <= '0;
        end else begin
            if (l3_wr) begin
                r_l3_vld[i_upd.l3_idx] <= 1'b1;
            end
            if (l4_wr) begin
                r_l4_vld[i_upd.l4_idx] <= 1'b1;
            end
        end
    end

    // Note a write to the entry being read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l3_rd_vld  <= 1'b0;
            r_l4_rd_vld  <= 1'b0;
            r_l3_fwd_hit <= 1'b0;
            r_l4_fwd_hit <= 1'b0;
        end else if (i_rd.en) begin
            r_l3_rd_vld  <= r_l3_vld[i_rd.l3_idx];
            r_l4_rd_vld  <= r_l4_vld[i_rd.l4_idx];
            r_l3_fwd_hit <= l3_wr && (i_upd.l3_idx == i_rd.l3_idx);
            r_l4_fwd_hit <= l4_wr && (i_upd.l4_idx == i_rd.l4_idx);
        end
    end

    // Hold the forwarded value alongside the read data
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_l3_fwd_data <= o_l3_next;
            r_l4_fwd_data <= o_l4_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/ethernet_header_classifier.sv -----
// The verdict passes the count stage and the output register once the final byte is
// taken. Throughput: one byte per cycle, and one frame per cycle down to one-byte
// frames, unless verdicts stall; the network and transport counters each take at
// most one read-modify-write per frame in their own RAM (registered read, write-back
// forwarded to the next read). Reset clears the byte parser, the pipeline and the
// counters' per-entry valid bits, so all counters read zero at once; no clearing pass.
`default_nettype none
`include "ethernet_header_classifier_defines.svh"

module ethernet_header_classifier (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ehc_in_if.sink    i_in,
    ehc_out_if.source o_out
);

    logic              accept;
    logic              frame_done;
    logic              s1_go;
    ehc_pkg::t_frame   frame;
    ehc_pkg::t_cnt_rd  cnt_rd;
    ehc_pkg::t_cnt_upd cnt_upd;
    logic [ehc_pkg::COUNT_WIDTH-1:0] l3_next, l4_next;

    logic              r_s1_valid;
    ehc_pkg::t_frame   r_s1;
    logic              r_out_valid;
    ehc_pkg::t_frame   r_out;
    logic [31:0]       r_out_l3, r_out_l4;

    // Handshake: take a byte while the count stage can move on
    assign s1_go      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign accept     = i_in.valid && i_in.ready;
    assign frame_done = accept && i_in.last_byte;

    ehc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_frame     (frame)
    );

    // Read counters on the final byte, write back as the frame leaves
    assign cnt_rd.en      = frame_done;
    assign cnt_rd.l3_idx  = frame.l3_idx;
    assign cnt_rd.l4_idx  = frame.l4_idx;
    assign cnt_upd.en      = s1_go;
    assign cnt_upd.l3_bump = r_s1.l3_bump;
    assign cnt_upd.l3_idx  = r_s1.l3_idx;
    assign cnt_upd.l4_bump = r_s1.l4_bump;
    assign cnt_upd.l4_idx  = r_s1.l4_idx;

    ehc_counter_bank u_counters (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (cnt_rd),
        .i_upd     (cnt_upd),
        .o_l3_next (l3_next),
        .o_l4_next (l4_next)
    );

    // Count stage and output register valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (frame_done) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Count stage and output register payload
    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            r_s1 <= frame;
        end
        if (s1_go) begin
            r_out    <= r_s1;
            r_out_l3 <= r_s1.l3_bump ? 32'(l3_next) : 32'd0;
            r_out_l4 <= r_s1.l4_bump ? 32'(l4_next) : 32'd0;
        end
    end

    // Drive the result request
    assign o_out.valid        = r_out_valid;
    assign o_out.verdict      = r_out.verdict;
    assign o_out.packet_class = r_out.cls;
    assign o_out.report_valid = r_out.report;
    assign o_out.frame_length = r_out.frame_length;
    assign o_out.ether_type   = r_out.ether_type;
    assign o_out.ip_protocol  = r_out.ip_protocol;
    assign o_out.src_addr     = r_out.src_addr;
    assign o_out.dst_addr     = r_out.dst_addr;
    assign o_out.src_port     = r_out.src_port;
    assign o_out.dst_port     = r_out.dst_port;
    assign o_out.l3_count     = r_out_l3;
    assign o_out.l4_count     = r_out_l4;

    // Checks
    `EHC_ASSERT_NOW(a_no_s1_overwrite, i_clk, i_rst_n, r_s1_valid && !s1_go, !frame_done,
        "final byte taken while the count stage is stalled")
    `EHC_ASSERT_NEXT(a_frame_enters_s1, i_clk, i_rst_n, frame_done, r_s1_valid,
        "finished frame did not reach the count stage")
    `EHC_ASSERT_NOW(a_report_passes, i_clk, i_rst_n, r_out_valid && r_out.report,
        !r_out.verdict, "report given for a dropped frame")
    `EHC_ASSERT_NOW(a_l4_count_class, i_clk, i_rst_n, r_out_valid && r_out_l4 != 32'd0,
        r_out.cls == ehc_pkg::CLS_TCP || r_out.cls == ehc_pkg::CLS_UDP ||
        r_out.cls == ehc_pkg::CLS_ICMP, "transport count on a non-transport class")

endmodule

`default_nettype wire

// ----- test/ehc_verdict_checker.sv -----
// Verdict checker for the Ethernet header classifier: watches the byte and verdict
// channels, predicts every frame's verdict and compares each one field by field.
// Depends on ehc_pkg, ehc_in_if and ehc_out_if.
`timescale 1ns / 1ps

module ehc_verdict_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ehc_in_if    i_bytes,
    ehc_out_if   i_verdicts,
    output int   o_fail_count,
    output int   o_pending
);
    import ehc_pkg::*;

    typedef struct packed {
        logic        verdict;
        t_class      cls;
        logic        report;
        logic [15:0] length;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] net_count;
        logic [31:0] l4_count;
    } frame_verdict_t;

    // Header fields of the frame in flight
    logic [15:0] byte_pos;
    logic [15:0] etype_held;
    logic [3:0]  ihl_held;
    logic [7:0]  proto_held;
    logic [31:0] src_ip_held;
    logic [31:0] dst_ip_held;
    logic [15:0] sport_held;
    logic [15:0] dport_held;

    // Class counters, wrapping at COUNT_WIDTH bits
    logic [COUNT_WIDTH-1:0] net_tally [L3_DEPTH];
    logic [COUNT_WIDTH-1:0] transport_tally [L4_DEPTH];

    frame_verdict_t verdicts_due [$];
    int             fails = 0;

    function automatic void clear_frame();
        byte_pos    = '0;
        etype_held  = '0;
        ihl_held    = '0;
        proto_held  = '0;
        src_ip_held = '0;
        dst_ip_held = '0;
        sport_held  = '0;
        dport_held  = '0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    // Advance the parser by one byte; on the final byte classify the frame,
    // bump its counters and queue the verdict it should get
    function automatic void take_byte(input logic [7:0] b, input logic last);
        frame_verdict_t   v;
        logic [3:0]       ihl_now;
        int unsigned      idx;
        int unsigned      base;
        int unsigned      len;
        int unsigned      need;
        logic             has_l4;
        logic [L4_AW-1:0] l4_sel;

        idx     = byte_pos;
        ihl_now = (idx == OFS_IHL) ? b[3:0] : ihl_held;

        // Capture header fields at their fixed offsets
        if (idx == OFS_TYPE_HI) etype_held[15:8] = b;
        if (idx == OFS_TYPE_LO) etype_held[7:0] = b;
        if (idx == OFS_IHL) ihl_held = ihl_now;
        if (idx == OFS_PROTO) proto_held = b;
        if (idx >= OFS_SRC_LO && idx <= OFS_SRC_HI) src_ip_held = {src_ip_held[23:0], b};
        if (idx >= OFS_DST_LO && idx <= OFS_DST_HI) dst_ip_held = {dst_ip_held[23:0], b};

        // Ports sit at the layer-4 offset whatever the protocol is
        base = L3_BASE + 4 * int'(ihl_now);
        if (idx == base) sport_held[15:8] = b;
        if (idx == base + 1) sport_held[7:0] = b;
        if (idx == base + 2) dport_held[15:8] = b;
        if (idx == base + 3) dport_held[7:0] = b;

        len = (idx >= LEN_MAX) ? LEN_MAX : idx + 1;
        if (!last) begin
            byte_pos = 16'(len);
            return;
        end

        v        = '0;
        v.length = 16'(len);
        need     = 0;
        has_l4   = 1'b0;
        l4_sel   = L4_TCP;
        if (len >= MIN_ETH) begin
            v.etype = etype_held;
            if (etype_held == ETYPE_VLAN || etype_held == ETYPE_QINQ) begin
                v.cls     = CLS_VLAN;
                v.verdict = (len < MIN_VLAN);
            end else if (etype_held == ETYPE_IPV6) begin
                v.cls                = CLS_IPV6;
                net_tally[L3_IPV6]  += 1'b1;
                v.net_count          = 32'(net_tally[L3_IPV6]);
                v.verdict            = (len < MIN_IPV6);
            end else if (etype_held == ETYPE_IPV4 && len >= MIN_IPV4) begin
                v.cls                = CLS_IPV4;
                net_tally[L3_IPV4]  += 1'b1;
                v.net_count          = 32'(net_tally[L3_IPV4]);
                v.proto              = proto_held;
                v.src_ip             = src_ip_held;
                v.dst_ip             = dst_ip_held;
                case (proto_held)
                    PROTO_TCP: begin
                        v.cls  = CLS_TCP;
                        need   = NEED_TCP;
                        l4_sel = L4_TCP;
                        has_l4 = 1'b1;
                    end
                    PROTO_UDP: begin
                        v.cls  = CLS_UDP;
                        need   = NEED_SHORT;
                        l4_sel = L4_UDP;
                        has_l4 = 1'b1;
                    end
                    PROTO_ICMP: begin
                        v.cls  = CLS_ICMP;
                        need   = NEED_SHORT;
                        l4_sel = L4_ICMP;
                        has_l4 = 1'b1;
                    end
                    default: ;
                endcase
                // Drop when the layer-4 header is cut off
                if (has_l4 && len < base + need) begin
                    v.verdict = 1'b1;
                end else begin
                    v.report = 1'b1;
                    if (has_l4) begin
                        transport_tally[l4_sel] += 1'b1;
                        v.l4_count               = 32'(transport_tally[l4_sel]);
                    end
                    if (v.cls == CLS_TCP || v.cls == CLS_UDP) begin
                        v.sport = sport_held;
                        v.dport = dport_held;
                    end
                end
            end else if (etype_held == ETYPE_ARP && len >= MIN_ARP) begin
                v.cls               = CLS_ARP;
                net_tally[L3_ARP]  += 1'b1;
                v.net_count         = 32'(net_tally[L3_ARP]);
                v.report            = 1'b1;
            end
        end
        verdicts_due.push_back(v);
        clear_frame();
    endfunction

    always @(posedge i_clk) begin
        frame_verdict_t want;
        if (!i_rst_n) begin
            clear_frame();
            foreach (net_tally[k]) net_tally[k] = '0;
            foreach (transport_tally[k]) transport_tally[k] = '0;
            verdicts_due.delete();
        end else begin
            // Compare a verdict request with the oldest prediction
            if (i_verdicts.valid && i_verdicts.ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("verdict with none predicted: class %0d, length %0d",
                           i_verdicts.packet_class, i_verdicts.frame_length);
                    fails++;
                end else begin
                    want = verdicts_due.pop_front();
                    check_field("verdict", want.verdict, i_verdicts.verdict);
                    check_field("packet_class", want.cls, i_verdicts.packet_class);
                    check_field("report_valid", want.report, i_verdicts.report_valid);
                    check_field("frame_length", want.length, i_verdicts.frame_length);
                    check_field("ether_type", want.etype, i_verdicts.ether_type);
                    check_field("ip_protocol", want.proto, i_verdicts.ip_protocol);
                    check_field("src_addr", want.src_ip, i_verdicts.src_addr);
                    check_field("dst_addr", want.dst_ip, i_verdicts.dst_addr);
                    check_field("src_port", want.sport, i_verdicts.src_port);
                    check_field("dst_port", want.dport, i_verdicts.dst_port);
                    check_field("l3_count", want.net_count, i_verdicts.l3_count);
                    check_field("l4_count", want.l4_count, i_verdicts.l4_count);
                end
            end
            // Feed each accepted byte request to the parser
            if (i_bytes.valid && i_bytes.ready) begin
                take_byte(i_bytes.data_byte, i_bytes.last_byte);
            end
        end
        o_fail_count <= fails;
        o_pending    <= verdicts_due.size();
    end

endmodule

// ----- test/tb.sv -----
// Top of the Ethernet header classifier testbench: clock, reset, frame stimulus,
// random back-pressure on the verdict side and the final verdict of the run.
// Depends on ehc_pkg, ehc_in_if, ehc_out_if, the classifier and ehc_verdict_checker.
`timescale 1ns / 1ps

module tb;
    import ehc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_BYTES  = 800;
    localparam int RANDOM_FRAMES = 20;
    localparam int DRAIN_CYCLES  = 10;
    localparam int MAX_GAP       = 18;
    localparam int LONG_FRAME    = 4096;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   verdicts_pending;
    bit   receiver_quiet;

    ehc_in_if  byte_ch ();
    ehc_out_if verdict_ch ();

    ethernet_header_classifier dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (verdict_ch)
    );

    ehc_verdict_checker u_verdict_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_bytes      (byte_ch),
        .i_verdicts   (verdict_ch),
        .o_fail_count (fail_count),
        .o_pending    (verdicts_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up on a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int pick_gap(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Build a frame with the given header fields over random or constant filler,
    // then stream it byte by byte
    task automatic send_frame(input logic [15:0] etype, input int len, input logic [3:0] ihl,
                              input logic [7:0] proto, input int fill);
        logic [7:0] frame_buf [$];
        bit         quiet;
        int         gap;
        for (int k = 0; k < len; k++) begin
            frame_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        end
        if (len > OFS_TYPE_HI) frame_buf[OFS_TYPE_HI] = etype[15:8];
        if (len > OFS_TYPE_LO) frame_buf[OFS_TYPE_LO] = etype[7:0];
        if (etype == ETYPE_IPV4) begin
            if (len > OFS_IHL) frame_buf[OFS_IHL] = {4'h4, ihl};
            if (len > OFS_PROTO) frame_buf[OFS_PROTO] = proto;
        end
        // Long frames go at full rate
        quiet = (len > LONG_FRAME) || ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++) begin
            gap = pick_gap(quiet);
            if (gap > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            byte_ch.valid     <= 1'b1;
            byte_ch.data_byte <= frame_buf[k];
            byte_ch.last_byte <= (k == len - 1);
            do @(posedge clk); while (!byte_ch.ready);
        end
    endtask

    // Stall the verdict side at random, with runs of no stalls
    initial begin
        int gap;
        verdict_ch.ready <= 1'b0;
        receiver_quiet = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 7) == 0) receiver_quiet = ~receiver_quiet;
            gap = pick_gap(receiver_quiet);
            if (gap > 0) begin
                verdict_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            verdict_ch.ready <= 1'b1;
            do @(posedge clk); while (!verdict_ch.valid);
        end
    end

    initial begin
        int          len;
        int          floor_len;
        int          need;
        int          pick;
        int          random_bytes;
        int          random_frames;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] etype;

        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.last_byte <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short frames, down to a single byte
        send_frame(16'h0000, 1, 4'd0, 8'd0, -1);
        send_frame(ETYPE_IPV4, 13, 4'd5, PROTO_TCP, -1);
        send_frame(16'h1234, 14, 4'd0, 8'd0, -1);
        // Tagged frames around their length limit
        send_frame(ETYPE_VLAN, 17, 4'd0, 8'd0, -1);
        send_frame(ETYPE_QINQ, 18, 4'd0, 8'd0, -1);
        // IPv6 around its length limit
        send_frame(ETYPE_IPV6, 53, 4'd0, 8'd0, -1);
        send_frame(ETYPE_IPV6, 54, 4'd0, 8'd0, -1);
        // IPv4 too short for its header
        send_frame(ETYPE_IPV4, 33, 4'd5, PROTO_TCP, -1);
        // Each transport just cut off and just complete
        send_frame(ETYPE_IPV4, 53, 4'd5, PROTO_TCP, -1);
        send_frame(ETYPE_IPV4, 54, 4'd5, PROTO_TCP, -1);
        send_frame(ETYPE_IPV4, 41, 4'd5, PROTO_UDP, -1);
        send_frame(ETYPE_IPV4, 42, 4'd5, PROTO_UDP, -1);
        send_frame(ETYPE_IPV4, 41, 4'd5, PROTO_ICMP, -1);
        send_frame(ETYPE_IPV4, 42, 4'd5, PROTO_ICMP, -1);
        send_frame(ETYPE_IPV4, 34, 4'd5, 8'h59, -1);
        // Small header lengths put the ports inside the IPv4 header
        send_frame(ETYPE_IPV4, 34, 4'd0, PROTO_TCP, -1);
        send_frame(ETYPE_IPV4, 34, 4'd2, PROTO_UDP, -1);
        // Largest header length over all-ones and all-zeros filler
        send_frame(ETYPE_IPV4, 82, 4'd15, PROTO_UDP, 8'hFF);
        send_frame(ETYPE_IPV4, 81, 4'd15, PROTO_UDP, 8'h00);
        // ARP around its length limit
        send_frame(ETYPE_ARP, 21, 4'd0, 8'd0, -1);
        send_frame(ETYPE_ARP, 22, 4'd0, 8'd0, -1);
        // Unknown EtherTypes at the extremes
        send_frame(16'hFFFF, 60, 4'd0, 8'd0, 8'hFF);
        send_frame(16'h0000, 60, 4'd0, 8'd0, 8'h00);

        random_bytes  = 0;
        random_frames = 0;
        while (random_bytes < RANDOM_BYTES || random_frames < RANDOM_FRAMES) begin
            pick  = $urandom_range(0, 99);
            ihl   = 4'd5;
            proto = 8'($urandom);
            etype = 16'($urandom);
            if (pick < 50) begin
                // Well-formed IPv4 with lengths around the layer-4 limit
                etype = ETYPE_IPV4;
                if ($urandom_range(0, 3) == 0) ihl = 4'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2: proto = PROTO_TCP;
                    3, 4, 5: proto = PROTO_UDP;
                    6, 7:    proto = PROTO_ICMP;
                    default: ;
                endcase
                need = (proto == PROTO_TCP) ? int'(NEED_TCP) :
                       (proto == PROTO_UDP || proto == PROTO_ICMP) ? int'(NEED_SHORT) : 0;
                floor_len = int'(L3_BASE) + 4 * int'(ihl) + need;
                if (floor_len < int'(MIN_IPV4)) floor_len = MIN_IPV4;
                len = floor_len + int'($urandom_range(0, 16)) - 4;
            end else if (pick < 60) begin
                etype = ETYPE_ARP;
                len   = $urandom_range(18, 30);
            end else if (pick < 70) begin
                etype = ETYPE_IPV6;
                len   = $urandom_range(48, 64);
            end else if (pick < 78) begin
                etype = ($urandom_range(0, 1) == 0) ? ETYPE_VLAN : ETYPE_QINQ;
                len   = $urandom_range(14, 24);
            end else if (pick < 88) begin
                len = $urandom_range(1, 13);
            end else begin
                len = $urandom_range(1, 40);
            end
            send_frame(etype, len, ihl, proto, -1);
            random_bytes  += len;
            random_frames++;
        end

        // Drain: wait for every predicted verdict before reporting the result
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (verdicts_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
